>>> rtl/hvss_pkg.sv
// Shared types and constants for the segment sweep active set.
package hvss_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned CoordBits  = 16;
  localparam int unsigned IdBits     = 10;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_NOHIT    = 3'd1,
    ST_ACCEPTED = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_PRIME,
    EX_SCAN,
    EX_PLACE,
    EX_EMIT
  } ex_state_e;

endpackage

>>> rtl/hv_segment_sweep_active_set.sv
// Top level of the sweep line active set for horizontal/vertical crossings.
// Input channel s_axis: one sweep event per request, tuser carries the kind
// (0 insert, 1 remove, 2 query, 3 dropped), tdata the segment, net and y range.
// Output channel m_axis: result requests; tdata holds hit segment and status,
// tlast marks the final result of an event.
// A two-entry command queue sits between intake and the table engine, so
// events are taken while the engine works or a result waits.
// The table is a memory walked one entry per cycle, but a query walk holds
// while a found hit waits behind a stalled output. An insert walks the
// entries above the new y; a remove and a query walk all active entries;
// an empty table or a full-table insert needs no walk. A query emits each
// hit once the next hit is found. The engine takes the next event the
// cycle after it loads its final result, so one event runs at a time.
// Reset empties the table and the queue; table contents need no clearing.
// When m_axis_tready is low, the engine holds at its next result and the
// queue fills, after which s_axis_tready drops.
module hv_segment_sweep_active_set #(
  parameter int unsigned TABLE_DEPTH = hvss_pkg::TableDepth,
  parameter int unsigned COORD_BITS  = hvss_pkg::CoordBits,
  parameter int unsigned ID_BITS     = hvss_pkg::IdBits,
  localparam int unsigned InW  = ((2 * ID_BITS + 2 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OutW = ((ID_BITS + 3 + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,  // segment_id, net_id, y_low, y_high
  input  logic [1:0]      s_axis_tuser,  // kind
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata,  // hit_segment, status
  output logic            m_axis_tlast
);
  import hvss_pkg::*;

  kind_e                 cmd_kind;
  logic                  cmd_valid, cmd_ready;
  logic [ID_BITS-1:0]    cmd_seg, cmd_net, res_seg;
  logic [COORD_BITS-1:0] cmd_ylo, cmd_yhi;
  status_e               res_status;

  hvss_front #(.COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (kind_e'(s_axis_tuser)),
    .in_seg_i   (s_axis_tdata[ID_BITS-1:0]),
    .in_net_i   (s_axis_tdata[2*ID_BITS-1:ID_BITS]),
    .in_ylo_i   (s_axis_tdata[2*ID_BITS+COORD_BITS-1:2*ID_BITS]),
    .in_yhi_i   (s_axis_tdata[2*ID_BITS+2*COORD_BITS-1:2*ID_BITS+COORD_BITS]),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_kind_o(cmd_kind),
    .cmd_seg_o(cmd_seg), .cmd_net_o(cmd_net), .cmd_ylo_o(cmd_ylo), .cmd_yhi_o(cmd_yhi)
  );

  hvss_back #(.TABLE_DEPTH(TABLE_DEPTH), .COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS))
  u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_kind_i(cmd_kind),
    .cmd_seg_i(cmd_seg), .cmd_net_i(cmd_net), .cmd_ylo_i(cmd_ylo), .cmd_yhi_i(cmd_yhi),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_seg_o   (res_seg),
    .res_status_o(res_status),
    .res_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = OutW'({res_status, res_seg});

endmodule

>>> rtl/hvss_front.sv
// Front end: request intake, kind decode and a small command queue.
module hvss_front #(
  parameter int unsigned COORD_BITS = hvss_pkg::CoordBits,
  parameter int unsigned ID_BITS    = hvss_pkg::IdBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hvss_pkg::kind_e       in_kind_i,
  input  logic [ID_BITS-1:0]    in_seg_i,
  input  logic [ID_BITS-1:0]    in_net_i,
  input  logic [COORD_BITS-1:0] in_ylo_i,
  input  logic [COORD_BITS-1:0] in_yhi_i,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output hvss_pkg::kind_e       cmd_kind_o,
  output logic [ID_BITS-1:0]    cmd_seg_o,
  output logic [ID_BITS-1:0]    cmd_net_o,
  output logic [COORD_BITS-1:0] cmd_ylo_o,
  output logic [COORD_BITS-1:0] cmd_yhi_o
);
  import hvss_pkg::*;

  localparam int unsigned CmdW = 2 + 2 * ID_BITS + 2 * COORD_BITS;

  logic [CmdW-1:0] mem_q [QueueDepth];
  logic            wp_q, wp_d, rp_q, rp_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  // unused kind is dropped here
  assign push        = in_valid_i && in_ready_o && (in_kind_i != KIND_NONE);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= {in_yhi_i, in_ylo_i, in_net_i, in_seg_i, in_kind_i};
  end

  assign {cmd_yhi_o, cmd_ylo_o, cmd_net_o, cmd_seg_o} = mem_q[rp_q][CmdW-1:2];
  assign cmd_kind_o = kind_e'(mem_q[rp_q][1:0]);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
`endif

endmodule

>>> rtl/hvss_back.sv
// Back end: ordered active table with insert, remove and range query.
module hvss_back #(
  parameter int unsigned TABLE_DEPTH = hvss_pkg::TableDepth,
  parameter int unsigned COORD_BITS  = hvss_pkg::CoordBits,
  parameter int unsigned ID_BITS     = hvss_pkg::IdBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  hvss_pkg::kind_e       cmd_kind_i,
  input  logic [ID_BITS-1:0]    cmd_seg_i,
  input  logic [ID_BITS-1:0]    cmd_net_i,
  input  logic [COORD_BITS-1:0] cmd_ylo_i,
  input  logic [COORD_BITS-1:0] cmd_yhi_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [ID_BITS-1:0]    res_seg_o,
  output hvss_pkg::status_e     res_status_o,
  output logic                  res_last_o
);
  import hvss_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EntW = COORD_BITS + 2 * ID_BITS;
  localparam logic [CntW-1:0] Full = CntW'(TABLE_DEPTH);

  // entry layout from the low bit up: segment, net, y
  logic [EntW-1:0]       mem_q [TABLE_DEPTH];
  logic [EntW-1:0]       rd_q;
  logic                  rd_en, wr_en;
  logic [IdxW-1:0]       rd_addr, wr_addr;
  logic [EntW-1:0]       wr_data;

  ex_state_e             st_q, st_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [CntW-1:0]       cur_q, cur_d;
  kind_e                 kind_q;
  logic [ID_BITS-1:0]    seg_q, net_q;
  logic [COORD_BITS-1:0] ylo_q, yhi_q;
  logic                  found_q, found_d;
  status_e               fin_q, fin_d;

  // output register plus one pending hit waiting for its last flag
  logic                  ov_q, ov_d;
  logic [ID_BITS-1:0]    os_q, os_d;
  status_e               ost_q, ost_d;
  logic                  ol_q, ol_d;
  logic                  pv_q, pv_d;
  logic [ID_BITS-1:0]    ps_q, ps_d;

  logic                  take, in_rng, scan_end, out_free, q_hold;
  logic [COORD_BITS-1:0] rd_y;
  logic [ID_BITS-1:0]    rd_seg, rd_net;
  logic [EntW-1:0]       new_ent;
  logic [CntW-1:0]       cur_inc, cur_dec;

  assign {rd_y, rd_net, rd_seg} = rd_q;
  assign new_ent     = {ylo_q, net_q, seg_q};
  assign cur_inc     = cur_q + 1'b1;
  assign cur_dec     = cur_q - 1'b1;
  assign scan_end    = (cur_inc == cnt_q);
  assign out_free    = !ov_q || res_ready_i;
  assign cmd_ready_o = (st_q == EX_IDLE);
  assign take        = cmd_valid_i && cmd_ready_o;
  assign in_rng      = (rd_y >= ylo_q) && (rd_y <= yhi_q) && (rd_net != net_q);
  assign q_hold      = in_rng && pv_q && !out_free;

  assign res_valid_o  = ov_q;
  assign res_seg_o    = os_q;
  assign res_status_o = ost_q;
  assign res_last_o   = ol_q;

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    cur_d   = cur_q;
    found_d = found_q;
    fin_d   = fin_q;
    pv_d    = pv_q;
    ps_d    = ps_q;
    ov_d    = ov_q && !res_ready_i;
    os_d    = os_q;
    ost_d   = ost_q;
    ol_d    = ol_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = new_ent;
    unique case (st_q)
      EX_IDLE: begin
        if (take) st_d = EX_PRIME;
      end
      EX_PRIME: begin
        found_d = 1'b0;
        pv_d    = 1'b0;
        cur_d   = '0;
        unique case (kind_q)
          KIND_INSERT: begin
            if (cnt_q == Full) begin
              fin_d = ST_FULL;
              st_d  = EX_EMIT;
            end else if (cnt_q == '0) begin
              wr_en = 1'b1;
              cnt_d = cnt_q + 1'b1;
              fin_d = ST_ACCEPTED;
              st_d  = EX_EMIT;
            end else begin
              // walk down from the top entry
              cur_d   = cnt_q - 1'b1;
              rd_en   = 1'b1;
              rd_addr = cur_d[IdxW-1:0];
              st_d    = EX_SCAN;
            end
          end
          KIND_REMOVE: begin
            if (cnt_q == '0) begin
              fin_d = ST_NOTFOUND;
              st_d  = EX_EMIT;
            end else begin
              rd_en = 1'b1;
              st_d  = EX_SCAN;
            end
          end
          default: begin
            if (cnt_q == '0) begin
              fin_d = ST_NOHIT;
              st_d  = EX_EMIT;
            end else begin
              rd_en = 1'b1;
              st_d  = EX_SCAN;
            end
          end
        endcase
      end
      EX_SCAN: begin
        unique case (kind_q)
          KIND_INSERT: begin
            // entries above the new y move up one row
            wr_en   = 1'b1;
            wr_addr = cur_inc[IdxW-1:0];
            if (rd_y > ylo_q) begin
              wr_data = rd_q;
              if (cur_q == '0) begin
                st_d = EX_PLACE;
              end else begin
                cur_d   = cur_dec;
                rd_en   = 1'b1;
                rd_addr = cur_dec[IdxW-1:0];
              end
            end else begin
              cnt_d = cnt_q + 1'b1;
              fin_d = ST_ACCEPTED;
              st_d  = EX_EMIT;
            end
          end
          KIND_REMOVE: begin
            // after the first match every entry moves down one row
            if (found_q) begin
              wr_en   = 1'b1;
              wr_addr = cur_dec[IdxW-1:0];
              wr_data = rd_q;
            end else if (rd_seg == seg_q) begin
              found_d = 1'b1;
            end
            if (scan_end) begin
              if (found_d) begin
                cnt_d = cnt_q - 1'b1;
                fin_d = ST_ACCEPTED;
              end else begin
                fin_d = ST_NOTFOUND;
              end
              st_d = EX_EMIT;
            end else begin
              cur_d   = cur_inc;
              rd_en   = 1'b1;
              rd_addr = cur_inc[IdxW-1:0];
            end
          end
          default: begin
            if (!q_hold) begin
              if (in_rng) begin
                if (pv_q) begin
                  ov_d  = 1'b1;
                  os_d  = ps_q;
                  ost_d = ST_HIT;
                  ol_d  = 1'b0;
                end
                pv_d = 1'b1;
                ps_d = rd_seg;
              end
              if (scan_end) begin
                fin_d = pv_d ? ST_HIT : ST_NOHIT;
                st_d  = EX_EMIT;
              end else begin
                cur_d   = cur_inc;
                rd_en   = 1'b1;
                rd_addr = cur_inc[IdxW-1:0];
              end
            end
          end
        endcase
      end
      EX_PLACE: begin
        wr_en = 1'b1;
        cnt_d = cnt_q + 1'b1;
        fin_d = ST_ACCEPTED;
        st_d  = EX_EMIT;
      end
      EX_EMIT: begin
        if (out_free) begin
          ov_d  = 1'b1;
          os_d  = (fin_q == ST_HIT) ? ps_q : '0;
          ost_d = fin_q;
          ol_d  = 1'b1;
          st_d  = EX_IDLE;
        end
      end
      default: st_d = EX_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= EX_IDLE;
      cnt_q <= '0;
      ov_q  <= 1'b0;
      pv_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
      pv_q  <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    found_q <= found_d;
    fin_q   <= fin_d;
    os_q    <= os_d;
    ost_q   <= ost_d;
    ol_q    <= ol_d;
    ps_q    <= ps_d;
    if (take) begin
      kind_q <= cmd_kind_i;
      seg_q  <= cmd_seg_i;
      net_q  <= cmd_net_i;
      ylo_q  <= cmd_ylo_i;
      yhi_q  <= cmd_yhi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full) else $error("active count past depth");
  a_cur_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == EX_SCAN |-> cur_q < cnt_q) else $error("scan past table end");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !res_ready_i |=> ov_q && $stable(os_q) && $stable(ost_q) && $stable(ol_q))
    else $error("result dropped while stalled");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == EX_IDLE |=> $stable(cnt_q)) else $error("count moved while idle");
`endif

endmodule

>>> sim/tb_hv_segment_sweep_active_set.sv
// Testbench for the sweep line active set: directed table plus random events against a predictor.
`timescale 1ns / 100ps

module tb_hv_segment_sweep_active_set;
  import hvss_pkg::*;

  localparam int unsigned InW  = ((2 * IdBits + 2 * CoordBits + 7) / 8) * 8;
  localparam int unsigned OutW = ((IdBits + 3 + 7) / 8) * 8;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic [IdBits-1:0] seg;
    logic [2:0]        status;
    logic              last;
  } result_t;

  typedef struct {
    kind_e                kind;
    logic [IdBits-1:0]    seg;
    logic [IdBits-1:0]    net;
    logic [CoordBits-1:0] ylo;
    logic [CoordBits-1:0] yhi;
    logic                 chk;
    status_e              status;
  } event_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [InW-1:0]  s_axis_tdata;
  logic [1:0]      s_axis_tuser;
  logic [OutW-1:0] m_axis_tdata;

  hv_segment_sweep_active_set u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  logic [CoordBits-1:0] act_y[$];
  logic [IdBits-1:0]    act_seg[$];
  logic [IdBits-1:0]    act_net[$];
  result_t              pending_results[$];
  event_t               evq[$];
  int                   errors = 0;
  int                   idle_cnt = 0;
  bit                   quiet = 0;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void predict_event(event_t e);
    int pos, n;
    result_t r;
    case (e.kind)
      KIND_INSERT: begin
        r = '{0, ST_FULL, 1};
        if (act_y.size() < TableDepth) begin
          pos = 0;
          while (pos < act_y.size() && act_y[pos] <= e.ylo) pos++;
          act_y.insert(pos, e.ylo);
          act_seg.insert(pos, e.seg);
          act_net.insert(pos, e.net);
          r.status = ST_ACCEPTED;
        end
        pending_results.push_back(r);
      end
      KIND_REMOVE: begin
        r = '{0, ST_NOTFOUND, 1};
        pos = 0;
        while (pos < act_seg.size() && act_seg[pos] != e.seg) pos++;
        if (pos < act_seg.size()) begin
          act_y.delete(pos);
          act_seg.delete(pos);
          act_net.delete(pos);
          r.status = ST_ACCEPTED;
        end
        pending_results.push_back(r);
      end
      KIND_QUERY: begin
        n = 0;
        foreach (act_y[i]) begin
          if (act_y[i] >= e.ylo && act_y[i] <= e.yhi && act_net[i] != e.net) begin
            pending_results.push_back('{act_seg[i], ST_HIT, 0});
            n++;
          end
        end
        if (n == 0) pending_results.push_back('{0, ST_NOHIT, 1});
        else pending_results[$].last = 1;
      end
      default: ;
    endcase
  endfunction

  function automatic event_t mk(kind_e k, int s, int n, int lo, int hi);
    event_t e;
    e.kind = k; e.seg = IdBits'(s); e.net = IdBits'(n);
    e.ylo = CoordBits'(lo); e.yhi = CoordBits'(hi); e.chk = 0;
    e.status = ST_HIT;
    return e;
  endfunction

  function automatic event_t mk_chk(kind_e k, int s, int n, int lo, int hi, status_e st);
    event_t e;
    e = mk(k, s, n, lo, hi);
    e.chk = 1; e.status = st;
    return e;
  endfunction

  // typed expectation already queued; keep the predictor state in step
  function automatic bit predict_check(event_t e);
    int prior_cnt;
    prior_cnt = pending_results.size();
    predict_event(e);
    if (pending_results[prior_cnt].status != pending_results[prior_cnt - 1].status) begin
      $display("%0t table row status %0d disagrees with predictor %0d", $time,
               pending_results[prior_cnt - 1].status, pending_results[prior_cnt].status);
      errors++;
    end
    pending_results.delete(prior_cnt);
    return 1;
  endfunction

  // sender
  initial begin
    event_t e;
    int gap, nrand, sel, k;
    s_axis_tvalid <= 0; s_axis_tdata <= '0; s_axis_tuser <= KIND_NONE;
    rst_ni <= 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    // directed table
    evq.push_back(mk_chk(KIND_QUERY, 0, 0, 0, 16'hffff, ST_NOHIT));
    evq.push_back(mk_chk(KIND_REMOVE, 5, 0, 0, 0, ST_NOTFOUND));
    evq.push_back(mk_chk(KIND_INSERT, 1023, 1023, 16'hffff, 0, ST_ACCEPTED));
    evq.push_back(mk_chk(KIND_INSERT, 0, 0, 0, 16'hffff, ST_ACCEPTED));
    evq.push_back(mk(KIND_INSERT, 7, 3, 100, 0));
    evq.push_back(mk(KIND_INSERT, 7, 4, 100, 0));
    evq.push_back(mk(KIND_INSERT, 8, 5, 100, 0));
    evq.push_back(mk(KIND_QUERY, 9, 4, 0, 16'hffff));
    evq.push_back(mk(KIND_QUERY, 9, 1023, 100, 100));
    evq.push_back(mk(KIND_QUERY, 9, 0, 200, 100));
    evq.push_back(mk(KIND_NONE, 1023, 1023, 16'hffff, 16'hffff));
    evq.push_back(mk(KIND_REMOVE, 7, 0, 0, 0));
    evq.push_back(mk(KIND_QUERY, 0, 0, 0, 16'hffff));
    evq.push_back(mk(KIND_QUERY, 0, 2, 16'hffff, 16'hffff));
    for (int i = 0; i < 62; i++) evq.push_back(mk(KIND_INSERT, i + 40, i & 3, i * 7, 0));
    evq.push_back(mk_chk(KIND_INSERT, 1, 1, 5, 0, ST_FULL));
    evq.push_back(mk(KIND_QUERY, 0, 1, 0, 16'hffff));
    evq.push_back(mk(KIND_REMOVE, 1023, 0, 0, 0));
    evq.push_back(mk(KIND_REMOVE, 0, 0, 0, 0));
    for (int i = 0; i < 62; i++) evq.push_back(mk(KIND_REMOVE, i + 40, 0, 0, 0));
    // random: mostly valid sweeps over small id and y pools
    nrand = 180;
    for (int i = 0; i < nrand; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) k = KIND_INSERT;
      else if (sel < 65) k = KIND_REMOVE;
      else if (sel < 95) k = KIND_QUERY;
      else k = KIND_NONE;
      if ($urandom_range(0, 9) < 8)
        e = mk(kind_e'(k), $urandom_range(0, 31), $urandom_range(0, 7),
               $urandom_range(0, 63) * 1000, $urandom_range(0, 63) * 1000 + $urandom_range(0, 999));
      else
        e = mk(kind_e'(k), $urandom, $urandom, $urandom, $urandom);
      evq.push_back(e);
    end
    foreach (evq[i]) begin
      e = evq[i];
      if (!quiet && i > evq.size() - 40) quiet = 1;
      if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 13);
        s_axis_tvalid <= 0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1;
      s_axis_tuser  <= e.kind;
      s_axis_tdata  <= InW'({e.yhi, e.ylo, e.net, e.seg});
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      if (e.chk) begin
        if (e.kind == KIND_QUERY) pending_results.push_back('{0, e.status, 1});
        else pending_results.push_back('{0, e.status, 1});
        void'(predict_check(e));
      end else predict_event(e);
    end
    s_axis_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver and checker
  initial begin
    result_t got, want;
    m_axis_tready <= 0;
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[IdBits-1:0], m_axis_tdata[IdBits+2:IdBits], m_axis_tlast};
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result, actual %h", $time, got);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.seg !== want.seg)
            $display("%0t hit_segment expected %0d actual %0d", $time, want.seg, got.seg);
          if (got.status !== want.status)
            $display("%0t status expected %0d actual %0d", $time, want.status, got.status);
          if (got.last !== want.last)
            $display("%0t last expected %0d actual %0d", $time, want.last, got.last);
          if (got !== want) errors++;
        end
      end
    end
  end

  // watchdog on accepted requests and results
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

>>> hv_segment_sweep_active_set.f
rtl/hvss_pkg.sv
rtl/hvss_front.sv
rtl/hvss_back.sv
rtl/hv_segment_sweep_active_set.sv
sim/tb_hv_segment_sweep_active_set.sv
